### hdl/u8dv_pkg.sv
package u8dv_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_CNT_W = 3;

  localparam logic [1:0] KIND_ASCII = 2'd0;
  localparam logic [1:0] KIND_LEAD  = 2'd1;
  localparam logic [1:0] KIND_CONT  = 2'd2;
  localparam logic [1:0] KIND_BAD   = 2'd3;

  localparam logic [1:0] STATUS_CODE      = 2'd0;
  localparam logic [1:0] STATUS_MALFORMED = 2'd1;
  localparam logic [1:0] STATUS_SKIP_END  = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] seq_len;
    logic [6:0] bits;
    logic       last;
  } entry_t;

  function automatic logic [30:0] overlong_limit(input logic [2:0] seq_len);
    logic [30:0] lim;
    case (seq_len)
      3'd2: lim = 31'h0000007F;
      3'd3: lim = 31'h000007FF;
      3'd4: lim = 31'h0000FFFF;
      3'd5: lim = 31'h001FFFFF;
      3'd6: lim = 31'h03FFFFFF;
      default: lim = 31'h00000000;
    endcase
    return lim;
  endfunction

endpackage

### hdl/u8dv_front.sv
module u8dv_front (
  input  logic [7:0]      data_byte,
  input  logic            buffer_end,
  output u8dv_pkg::entry_t entry
);

  always_comb begin
    entry.last    = buffer_end;
    entry.kind    = u8dv_pkg::KIND_BAD;
    entry.seq_len = 3'd0;
    entry.bits    = 7'd0;
    if (!data_byte[7]) begin
      entry.kind    = u8dv_pkg::KIND_ASCII;
      entry.seq_len = 3'd1;
      entry.bits    = data_byte[6:0];
    end else if (!data_byte[6]) begin
      entry.kind = u8dv_pkg::KIND_CONT;
      entry.bits = {1'b0, data_byte[5:0]};
    end else if (!data_byte[5]) begin
      entry.kind    = u8dv_pkg::KIND_LEAD;
      entry.seq_len = 3'd2;
      entry.bits    = {2'b0, data_byte[4:0]};
    end else if (!data_byte[4]) begin
      entry.kind    = u8dv_pkg::KIND_LEAD;
      entry.seq_len = 3'd3;
      entry.bits    = {3'b0, data_byte[3:0]};
    end else if (!data_byte[3]) begin
      entry.kind    = u8dv_pkg::KIND_LEAD;
      entry.seq_len = 3'd4;
      entry.bits    = {4'b0, data_byte[2:0]};
    end else if (!data_byte[2]) begin
      entry.kind    = u8dv_pkg::KIND_LEAD;
      entry.seq_len = 3'd5;
      entry.bits    = {5'b0, data_byte[1:0]};
    end else if (!data_byte[1]) begin
      entry.kind    = u8dv_pkg::KIND_LEAD;
      entry.seq_len = 3'd6;
      entry.bits    = {6'b0, data_byte[0]};
    end
  end

endmodule

### hdl/u8dv_queue.sv
module u8dv_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  u8dv_pkg::entry_t push_entry,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output u8dv_pkg::entry_t head_entry
);

  u8dv_pkg::entry_t                       slots [u8dv_pkg::QUEUE_DEPTH];
  logic [u8dv_pkg::QUEUE_PTR_W-1:0]       wr_ptr;
  logic [u8dv_pkg::QUEUE_PTR_W-1:0]       rd_ptr;
  logic [u8dv_pkg::QUEUE_CNT_W-1:0]       count;

  assign full       = (count == u8dv_pkg::QUEUE_CNT_W'(u8dv_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= u8dv_pkg::QUEUE_CNT_W'(u8dv_pkg::QUEUE_DEPTH))
    else $error("queue count beyond its depth");

  assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("word taken from an empty queue");

endmodule

### hdl/u8dv_back.sv
module u8dv_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  u8dv_pkg::entry_t head_entry,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [30:0]      code_point,
  output logic [1:0]       status,
  output logic             last_result
);

  logic [2:0]  bytes_remaining;
  logic [2:0]  sequence_length;
  logic [30:0] partial_value;
  logic        skipping_after_error;

  logic [2:0]  bytes_remaining_next;
  logic [2:0]  sequence_length_next;
  logic [30:0] partial_value_next;
  logic        skipping_after_error_next;

  logic        emit;
  logic [30:0] emit_cp;
  logic [1:0]  emit_status;
  logic        emit_last;

  logic [30:0] shifted;
  logic [2:0]  rem_dec;

  assign pop     = head_valid && (!out_valid || !out_stall);
  assign shifted = {partial_value[24:0], head_entry.bits[5:0]};
  assign rem_dec = bytes_remaining - 3'd1;

  always_comb begin
    bytes_remaining_next      = bytes_remaining;
    sequence_length_next      = sequence_length;
    partial_value_next        = partial_value;
    skipping_after_error_next = skipping_after_error;
    emit        = 1'b0;
    emit_cp     = '0;
    emit_status = u8dv_pkg::STATUS_CODE;
    emit_last   = head_entry.last;
    if (skipping_after_error) begin
      if (head_entry.last) begin
        skipping_after_error_next = 1'b0;
        emit        = 1'b1;
        emit_status = u8dv_pkg::STATUS_SKIP_END;
      end
    end else if (bytes_remaining == 3'd0) begin
      case (head_entry.kind)
        u8dv_pkg::KIND_ASCII: begin
          emit    = 1'b1;
          emit_cp = {24'd0, head_entry.bits};
        end
        u8dv_pkg::KIND_LEAD: begin
          if (head_entry.last) begin
            emit        = 1'b1;
            emit_status = u8dv_pkg::STATUS_MALFORMED;
          end else begin
            sequence_length_next = head_entry.seq_len;
            bytes_remaining_next = head_entry.seq_len - 3'd1;
            partial_value_next   = {24'd0, head_entry.bits};
          end
        end
        default: begin
          emit        = 1'b1;
          emit_status = u8dv_pkg::STATUS_MALFORMED;
        end
      endcase
    end else if (head_entry.kind != u8dv_pkg::KIND_CONT) begin
      emit        = 1'b1;
      emit_status = u8dv_pkg::STATUS_MALFORMED;
    end else if (rem_dec != 3'd0) begin
      if (head_entry.last) begin
        emit        = 1'b1;
        emit_status = u8dv_pkg::STATUS_MALFORMED;
      end else begin
        bytes_remaining_next = rem_dec;
        partial_value_next   = shifted;
      end
    end else begin
      emit = 1'b1;
      if (shifted <= u8dv_pkg::overlong_limit(sequence_length)) begin
        emit_status = u8dv_pkg::STATUS_MALFORMED;
      end else begin
        emit_cp              = shifted;
        bytes_remaining_next = 3'd0;
        sequence_length_next = 3'd0;
        partial_value_next   = '0;
      end
    end
    if (emit && emit_status == u8dv_pkg::STATUS_MALFORMED) begin
      bytes_remaining_next      = 3'd0;
      sequence_length_next      = 3'd0;
      partial_value_next        = '0;
      skipping_after_error_next = !head_entry.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining      <= 3'd0;
      sequence_length      <= 3'd0;
      partial_value        <= '0;
      skipping_after_error <= 1'b0;
      out_valid            <= 1'b0;
    end else begin
      if (pop) begin
        bytes_remaining      <= bytes_remaining_next;
        sequence_length      <= sequence_length_next;
        partial_value        <= partial_value_next;
        skipping_after_error <= skipping_after_error_next;
        out_valid            <= emit;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      code_point  <= emit_cp;
      status      <= emit_status;
      last_result <= emit_last;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != u8dv_pkg::STATUS_CODE |-> code_point == 31'd0)
    else $error("code point not cleared on an error word");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == u8dv_pkg::STATUS_SKIP_END |-> last_result)
    else $error("skip end reported before the buffer end");

  assert property (@(posedge clk) disable iff (rst)
    skipping_after_error |-> bytes_remaining == 3'd0 && sequence_length == 3'd0)
    else $error("sequence still open while skipping");

endmodule

### hdl/utf8_stream_decode_validate_unit.sv
// UTF-8 stream decoder and validator for the 31-bit form with sequences of
// 1 to 6 bytes. The input channel (in_valid, in_stall) carries one word per
// byte: data_byte and buffer_end, which marks the last byte of a buffer.
// The output channel (out_valid, out_stall) carries code_point, status and
// last_result. A word with status 0 holds a decoded code point, status 1
// reports the first malformation of a buffer, and status 2 closes a buffer
// in which an error was already reported. Every buffer ends with a word that
// has last_result set.
// Bytes are classified on entry and pass through a four-entry queue to the
// sequence tracker, which writes the output register. One byte is taken in
// each cycle while the queue is not full; the result that a byte completes is
// written into the output register when that byte is popped from the queue.
// When the receiver stalls, the output word holds and the queue fills;
// in_stall rises once all four entries are occupied.
// Synchronous reset empties the queue, drops the output word and clears all
// sequence state, so the next byte is read as the start of a new buffer.
module utf8_stream_decode_validate_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        buffer_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [30:0] code_point,
  output logic [1:0]  status,
  output logic        last_result
);

  u8dv_pkg::entry_t in_entry;
  u8dv_pkg::entry_t head_entry;
  logic             head_valid;
  logic             queue_full;
  logic             pop;

  assign in_stall = queue_full;

  u8dv_front u_front (
    .data_byte  (data_byte),
    .buffer_end (buffer_end),
    .entry      (in_entry)
  );

  u8dv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (in_valid && !queue_full),
    .push_entry (in_entry),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  u8dv_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_entry  (head_entry),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .code_point  (code_point),
    .status      (status),
    .last_result (last_result)
  );

endmodule

### sim/utf8_decode_checker.sv
module utf8_decode_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        buffer_end,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [30:0] code_point,
  input  logic [1:0]  status,
  input  logic        last_result,
  output int          mismatches,
  output int          pending_words,
  output int          live_bytes,
  output int          words_seen,
  output int          error_words
);

  typedef struct packed {
    logic [30:0] cp;
    logic [1:0]  st;
    logic        last;
  } u8_word_t;

  u8_word_t    expected_words[$];
  logic [2:0]  bytes_left;
  logic [2:0]  seq_len;
  logic [30:0] partial;
  logic        skipping;
  int          n_mismatch;
  int          n_live;
  int          n_words;
  int          n_errors;

  initial begin
    n_mismatch = 0;
    n_live     = 0;
    n_words    = 0;
    n_errors   = 0;
  end

  function automatic void clear_decoder();
    bytes_left = '0;
    seq_len    = '0;
    partial    = '0;
    skipping   = 1'b0;
  endfunction

  function automatic bit report_malformed(input logic fin, output u8_word_t w);
    clear_decoder();
    skipping = !fin;
    w.cp   = '0;
    w.st   = u8dv_pkg::STATUS_MALFORMED;
    w.last = fin;
    return 1'b1;
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, input logic fin,
                                     output u8_word_t w);
    logic [30:0] limit;
    w = '0;
    if (skipping) begin
      if (!fin) return 1'b0;
      clear_decoder();
      w.st   = u8dv_pkg::STATUS_SKIP_END;
      w.last = 1'b1;
      return 1'b1;
    end
    if (bytes_left == 3'd0) begin
      if (b < 8'h80) begin
        w.cp   = {23'd0, b};
        w.st   = u8dv_pkg::STATUS_CODE;
        w.last = fin;
        return 1'b1;
      end
      if (b < 8'hC0 || b >= 8'hFE) return report_malformed(fin, w);
      if (b < 8'hE0) begin
        seq_len = 3'd2;
        partial = {26'd0, b[4:0]};
      end else if (b < 8'hF0) begin
        seq_len = 3'd3;
        partial = {27'd0, b[3:0]};
      end else if (b < 8'hF8) begin
        seq_len = 3'd4;
        partial = {28'd0, b[2:0]};
      end else if (b < 8'hFC) begin
        seq_len = 3'd5;
        partial = {29'd0, b[1:0]};
      end else begin
        seq_len = 3'd6;
        partial = {30'd0, b[0]};
      end
      if (fin) return report_malformed(1'b1, w);
      bytes_left = seq_len - 3'd1;
      return 1'b0;
    end
    if (b[7:6] != 2'b10) return report_malformed(fin, w);
    partial    = {partial[24:0], b[5:0]};
    bytes_left = bytes_left - 3'd1;
    if (bytes_left != 3'd0) begin
      if (fin) return report_malformed(1'b1, w);
      return 1'b0;
    end
    case (seq_len)
      3'd2:    limit = 31'h0000007F;
      3'd3:    limit = 31'h000007FF;
      3'd4:    limit = 31'h0000FFFF;
      3'd5:    limit = 31'h001FFFFF;
      3'd6:    limit = 31'h03FFFFFF;
      default: limit = 31'h00000000;
    endcase
    if (partial <= limit) return report_malformed(fin, w);
    w.cp    = partial;
    w.st    = u8dv_pkg::STATUS_CODE;
    w.last  = fin;
    seq_len = '0;
    partial = '0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    u8_word_t w;
    if (rst) begin
      clear_decoder();
      expected_words.delete();
    end else begin
      if (in_valid && !in_stall) begin
        if (!(skipping && !buffer_end)) n_live++;
        if (decode_byte(data_byte, buffer_end, w)) expected_words.push_back(w);
      end
      if (out_valid && !out_stall) begin
        n_words++;
        if (status == u8dv_pkg::STATUS_MALFORMED) n_errors++;
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: code_point %h status %0d last %0d",
                 code_point, status, last_result);
          n_mismatch++;
        end else begin
          w = expected_words.pop_front();
          if (code_point !== w.cp) begin
            $error("code_point: expected %h, got %h", w.cp, code_point);
            n_mismatch++;
          end
          if (status !== w.st) begin
            $error("status: expected %0d, got %0d", w.st, status);
            n_mismatch++;
          end
          if (last_result !== w.last) begin
            $error("last_result: expected %0d, got %0d", w.last, last_result);
            n_mismatch++;
          end
        end
      end
    end
    mismatches    <= n_mismatch;
    pending_words <= expected_words.size();
    live_bytes    <= n_live;
    words_seen    <= n_words;
    error_words   <= n_errors;
  end

  final begin
    if (expected_words.size() != 0)
      $display("%0d expected words never arrived", expected_words.size());
  end

endmodule

### sim/tb.sv
module tb;

  localparam logic [8:0] DIRECTED [26] = '{
    9'h100, 9'h07F, 9'h0C2, 9'h080,
    9'h0FD, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF, 9'h1BF,
    9'h0C1, 9'h0BF, 9'h141,
    9'h1FE,
    9'h080, 9'h1FF,
    9'h0E0, 9'h041, 9'h100,
    9'h0F0, 9'h190,
    9'h1C3,
    9'h0F7, 9'h0BF, 9'h0BF, 9'h1BF
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        buffer_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [30:0] code_point;
  logic [1:0]  status;
  logic        last_result;

  int mismatches;
  int pending_words;
  int live_bytes;
  int words_seen;
  int error_words;
  int bytes_fed = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int holds_done = 0;

  always #10 clk = ~clk;

  utf8_stream_decode_validate_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .buffer_end(buffer_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .code_point(code_point), .status(status), .last_result(last_result)
  );

  utf8_decode_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .buffer_end(buffer_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .code_point(code_point), .status(status), .last_result(last_result),
    .mismatches(mismatches), .pending_words(pending_words),
    .live_bytes(live_bytes), .words_seen(words_seen), .error_words(error_words)
  );

  function automatic logic [31:0] top_of_len(input int n);
    case (n)
      1:       return 32'h0000007F;
      2:       return 32'h000007FF;
      3:       return 32'h0000FFFF;
      4:       return 32'h001FFFFF;
      5:       return 32'h03FFFFFF;
      default: return 32'h7FFFFFFF;
    endcase
  endfunction

  function automatic logic [7:0] lead_prefix(input int n);
    case (n)
      1:       return 8'h00;
      2:       return 8'hC0;
      3:       return 8'hE0;
      4:       return 8'hF0;
      5:       return 8'hF8;
      default: return 8'hFC;
    endcase
  endfunction

  task automatic put_byte(input logic [7:0] b, input logic fin);
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    buffer_end <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_fed++;
  endtask

  task automatic send_buffer();
    logic [7:0]  seq[6];
    logic [31:0] v;
    logic [31:0] lowest;
    int          nseq;
    int          n;
    int          len;
    int          mode;
    int          k;
    int          s;
    int          i;
    nseq = $urandom_range(1, 6);
    for (s = 0; s < nseq; s++) begin
      n      = $urandom_range(1, 6);
      mode   = $urandom_range(0, 29);
      lowest = (n == 1) ? 32'd0 : top_of_len(n - 1) + 32'd1;
      case ($urandom_range(0, 7))
        0:       v = lowest;
        1:       v = top_of_len(n);
        default: v = $urandom_range(top_of_len(n), lowest);
      endcase
      if (mode == 1 && n > 1)
        v = ($urandom_range(0, 1) == 0) ? lowest - 32'd1 : $urandom_range(lowest - 32'd1, 0);
      len = n;
      for (k = 0; k < n; k++) begin
        if (k == 0) seq[k] = lead_prefix(n) | 8'(v >> (6 * (n - 1)));
        else        seq[k] = 8'h80 | 8'((v >> (6 * (n - 1 - k))) & 32'h3F);
      end
      if (mode == 0 || (mode == 1 && n == 1)) begin
        seq[0] = 8'($urandom_range(0, 255));
        len    = 1;
      end else if (mode == 2 && n > 1) begin
        k = $urandom_range(1, n - 1);
        case ($urandom_range(0, 2))
          0:       seq[k] = {2'b00, 6'($urandom_range(0, 63))};
          1:       seq[k] = {2'b01, 6'($urandom_range(0, 63))};
          default: seq[k] = {2'b11, 6'($urandom_range(0, 63))};
        endcase
      end else if (mode == 3 && n > 1 && s == nseq - 1) begin
        len = $urandom_range(1, n - 1);
      end
      for (i = 0; i < len; i++)
        put_byte(seq[i], (s == nseq - 1) && (i == len - 1));
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if ((holds_done == 0 && bytes_fed >= 300) || (holds_done == 1 && bytes_fed >= 800)) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (DIRECTED[j]) put_byte(DIRECTED[j][7:0], DIRECTED[j][8]);
    while (bytes_fed < 1150) send_buffer();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    while (bytes_fed < 1330) send_buffer();
    in_valid <= 1'b0;
    wait (pending_words == 0);
    repeat (20) @(posedge clk);
    $display("Fed %0d bytes, %0d of them decoded rather than dropped, in varied buffers.",
             bytes_fed, live_bytes);
    $display("Checked %0d result words, %0d of them malformation reports, across two long holds.",
             words_seen, error_words);
    if (mismatches == 0 && pending_words == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
